@@ design/bei_pkg.sv @@
package bei_pkg;

    // Defaults for the top-level parameters.
    localparam int BISECT_STEPS_DEF = 20;
    localparam int FRAC_BITS_DEF    = 20;

    // Scale of the handle and progress fields as they arrive.
    localparam int IN_FRAC = 20;

    // Field widths of the streams.
    localparam int VALUE_W  = 32;
    localparam int HANDLE_W = 23;
    localparam int PROG_W   = 21;

    // Input tdata layout, first field in the lowest bits, padded to whole bytes.
    localparam int START_LSB = 0;
    localparam int END_LSB   = START_LSB + VALUE_W;
    localparam int HIN_LSB   = END_LSB + VALUE_W;
    localparam int HOUT_LSB  = HIN_LSB + HANDLE_W;
    localparam int PROG_LSB  = HOUT_LSB + HANDLE_W;
    localparam int S_FIELDS_W = PROG_LSB + PROG_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = VALUE_W;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Internal widths as a function of the number of fraction bits.
    // a: first control abscissa, b: one minus the second handle, x: progress.
    function automatic int a_width(input int frac);
        return frac + 3;
    endfunction

    function automatic int b_width(input int frac);
        return frac + 4;
    endfunction

    function automatic int x_width(input int frac);
        return frac + 1;
    endfunction

    // Context carried along the search: {start, end, a, b, x}, x lowest.
    function automatic int ctx_width(input int frac);
        return 2 * VALUE_W + a_width(frac) + b_width(frac) + x_width(frac);
    endfunction

endpackage

@@ design/bei_step.sv @@
module bei_step
    import bei_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [ctx_width(FRAC_BITS)-1:0]    in_ctx,
    input  logic [FRAC_BITS:0]                 in_lo,
    input  logic [FRAC_BITS:0]                 in_hi,
    output logic                               out_valid,
    output logic [ctx_width(FRAC_BITS)-1:0]    out_ctx,
    output logic [FRAC_BITS:0]                 out_lo,
    output logic [FRAC_BITS:0]                 out_hi,
    output logic [FRAC_BITS:0]                 out_t
);

    localparam int F    = FRAC_BITS;
    localparam int TW   = F + 1;
    localparam int AW   = a_width(F);
    localparam int BW   = b_width(F);
    localparam int XW   = x_width(F);
    localparam int CXW  = ctx_width(F);
    localparam int P1W  = AW + TW + 1 - F;
    localparam int P2W  = BW + TW + 1 - F;
    localparam int SW   = P2W + 3;
    localparam int B_LO = XW;
    localparam int A_LO = XW + BW;
    localparam logic [TW-1:0] ONE = {1'b1, {F{1'b0}}};

    // Stage 0: midpoint of the current interval and its complement.
    logic [TW:0]    mid_sum;
    logic [TW-1:0]  t0_next;
    logic           v0_reg;
    logic [CXW-1:0] ctx0_reg;
    logic [TW-1:0]  lo0_reg, hi0_reg, t0_reg, u0_reg;

    assign mid_sum = {1'b0, in_lo} + {1'b0, in_hi};
    assign t0_next = mid_sum[TW:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx0_reg <= in_ctx;
            lo0_reg  <= in_lo;
            hi0_reg  <= in_hi;
            t0_reg   <= t0_next;
            u0_reg   <= ONE - t0_next;
        end
    end

    // Stage 1: t*t and t*u.
    logic [2*TW-1:0] tt_full, tu_full;
    logic            v1_reg;
    logic [CXW-1:0]  ctx1_reg;
    logic [TW-1:0]   lo1_reg, hi1_reg, t1_reg, u1_reg, tt1_reg, tu1_reg;

    assign tt_full = t0_reg * t0_reg;
    assign tu_full = t0_reg * u0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx1_reg <= ctx0_reg;
            lo1_reg  <= lo0_reg;
            hi1_reg  <= hi0_reg;
            t1_reg   <= t0_reg;
            u1_reg   <= u0_reg;
            tt1_reg  <= tt_full[F +: TW];
            tu1_reg  <= tu_full[F +: TW];
        end
    end

    // Stage 2: the three Bernstein weights (the first two without their factor of three).
    logic [2*TW-1:0] w1_full, w2_full, w3_full;
    logic            v2_reg;
    logic [CXW-1:0]  ctx2_reg;
    logic [TW-1:0]   lo2_reg, hi2_reg, t2_reg, w1_2_reg, w2_2_reg, w3_2_reg;

    assign w1_full = tu1_reg * u1_reg;
    assign w2_full = tt1_reg * u1_reg;
    assign w3_full = tt1_reg * t1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx2_reg <= ctx1_reg;
            lo2_reg  <= lo1_reg;
            hi2_reg  <= hi1_reg;
            t2_reg   <= t1_reg;
            w1_2_reg <= w1_full[F +: TW];
            w2_2_reg <= w2_full[F +: TW];
            w3_2_reg <= w3_full[F +: TW];
        end
    end

    // Stage 3: weights times the control abscissas, floored back to scale.
    logic signed [AW-1:0]   a_s;
    logic signed [BW-1:0]   b_s;
    logic signed [AW+TW:0]  pa_full;
    logic signed [BW+TW:0]  pb_full;
    logic                   v3_reg;
    logic [CXW-1:0]         ctx3_reg;
    logic [TW-1:0]          lo3_reg, hi3_reg, t3_reg, w3_3_reg;
    logic signed [P1W-1:0]  p1_reg;
    logic signed [P2W-1:0]  p2_reg;

    assign a_s     = $signed(ctx2_reg[A_LO +: AW]);
    assign b_s     = $signed(ctx2_reg[B_LO +: BW]);
    assign pa_full = a_s * $signed({1'b0, w1_2_reg});
    assign pb_full = b_s * $signed({1'b0, w2_2_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx3_reg <= ctx2_reg;
            lo3_reg  <= lo2_reg;
            hi3_reg  <= hi2_reg;
            t3_reg   <= t2_reg;
            w3_3_reg <= w3_2_reg;
            p1_reg   <= pa_full[AW+TW:F];
            p2_reg   <= pb_full[BW+TW:F];
        end
    end

    // Stage 4: curve x, compare against the target and narrow the interval.
    logic signed [SW-1:0] p1x, p2x, w3x, xx, cx;
    logic                 less;
    logic [TW-1:0]        lo4_next, hi4_next;
    logic                 v4_reg;
    logic [CXW-1:0]       ctx4_reg;
    logic [TW-1:0]        lo4_reg, hi4_reg, t4_reg;

    assign p1x  = SW'(p1_reg);
    assign p2x  = SW'(p2_reg);
    assign w3x  = SW'($signed({1'b0, w3_3_reg}));
    assign xx   = SW'($signed({1'b0, ctx3_reg[XW-1:0]}));
    assign cx   = p1x + (p1x <<< 1) + p2x + (p2x <<< 1) + w3x;
    assign less = cx < xx;

    assign lo4_next = less ? t3_reg : lo3_reg;
    assign hi4_next = less ? hi3_reg : t3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx4_reg <= ctx3_reg;
            lo4_reg  <= lo4_next;
            hi4_reg  <= hi4_next;
            t4_reg   <= t3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_ctx   = ctx4_reg;
    assign out_lo    = lo4_reg;
    assign out_hi    = hi4_reg;
    assign out_t     = t4_reg;

endmodule

@@ design/bei_blend.sv @@
module bei_blend
    import bei_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  value_t             in_start,
    input  value_t             in_end,
    input  logic [FRAC_BITS:0] in_t,
    output logic               out_valid,
    output value_t             out_value
);

    localparam int F  = FRAC_BITS;
    localparam int TW = F + 1;
    localparam int KW = F + 2;
    localparam int DW = VALUE_W + 1;
    localparam int PW = TW + 1 + DW;
    localparam int RW = PW - F + 1;
    localparam logic [KW-1:0] THREE = {2'b11, {F{1'b0}}};
    localparam logic signed [RW-1:0] SAT_HI = RW'(64'sd2147483647);
    localparam logic signed [RW-1:0] SAT_LO = RW'(-64'sd2147483648);

    // Stage 0: t*t, 3 - 2t and the span of the output values.
    logic [2*TW-1:0]      tt_full;
    logic                 v0_reg;
    value_t               start0_reg;
    logic signed [DW-1:0] diff0_reg;
    logic [TW-1:0]        tt0_reg;
    logic [KW-1:0]        k0_reg;

    assign tt_full = in_t * in_t;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start0_reg <= in_start;
            diff0_reg  <= DW'(in_end) - DW'(in_start);
            tt0_reg    <= tt_full[F +: TW];
            k0_reg     <= THREE - {in_t, 1'b0};
        end
    end

    // Stage 1: smoothstep weight, which never exceeds one.
    logic [TW+KW-1:0]     s_full;
    logic                 v1_reg;
    value_t               start1_reg;
    logic signed [DW-1:0] diff1_reg;
    logic [TW-1:0]        s1_reg;

    assign s_full = tt0_reg * k0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start1_reg <= start0_reg;
            diff1_reg  <= diff0_reg;
            s1_reg     <= s_full[F +: TW];
        end
    end

    // Stage 2: weight times span.
    logic signed [PW-1:0] prod_full;
    logic                 v2_reg;
    value_t               start2_reg;
    logic signed [PW-1:0] prod2_reg;

    assign prod_full = $signed({1'b0, s1_reg}) * diff1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            start2_reg <= start1_reg;
            prod2_reg  <= prod_full;
        end
    end

    // Stage 3: add the start value and saturate to 32 bits.
    logic signed [RW-1:0] rsum;
    value_t               r3_next;
    logic                 v3_reg;
    value_t               r3_reg;

    assign rsum = RW'(start2_reg) + RW'($signed(prod2_reg[PW-1:F]));

    always_comb begin
        if (rsum > SAT_HI) begin
            r3_next = SAT_HI[VALUE_W-1:0];
        end else if (rsum < SAT_LO) begin
            r3_next = SAT_LO[VALUE_W-1:0];
        end else begin
            r3_next = rsum[VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r3_reg <= r3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_value = r3_reg;

endmodule

@@ design/bei_obuf.sv @@
module bei_obuf
    import bei_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  value_t in_data,
    output logic   en,
    output logic   m_tvalid,
    input  logic   m_tready,
    output value_t m_tdata
);

    logic   out_valid_reg, out_valid_next;
    value_t out_data_reg, out_data_next;
    logic   skid_valid_reg, skid_valid_next;
    value_t skid_data_reg, skid_data_next;
    logic   take;

    // The pipeline moves only while the skid entry is free, so a result that
    // leaves the pipeline always has a place to land.
    assign en   = !skid_valid_reg;
    assign take = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || take) begin
            out_valid_next = in_valid;
            out_data_next  = in_data;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/bezier_easing_interpolator_top.sv @@
// Channel   Dir  tdata fields (lowest bit first)                            Request
// s_        in   start_value, end_value, handle_in, handle_out, progress    one easing
// m_        out  eased_value                                                one result
//
// One request enters per clock while s_tready is high. The path is one input
// stage, five stages per bisection step (midpoint, two product levels, handle
// products, curve sum and compare), four blend stages and the output register.
// aresetn is synchronous and clears only the valid bits, also those of the output buffer.
// A stall on m_ freezes the whole pipeline once the output skid entry fills;
// s_tready comes straight from that register.
module bezier_easing_interpolator_top
    import bei_pkg::*;
#(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // start_value[31:0], end_value[63:32], handle_in[86:64],
    // handle_out[109:87], progress[130:110], zero padding[135:131]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // eased_value[31:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int F   = FRAC_BITS;
    localparam int TW  = F + 1;
    localparam int AW  = a_width(F);
    localparam int BW  = b_width(F);
    localparam int XW  = x_width(F);
    localparam int CXW = ctx_width(F);
    localparam int END_POS   = XW + BW + AW;
    localparam int START_POS = END_POS + VALUE_W;
    localparam logic [TW-1:0]        ONE   = {1'b1, {F{1'b0}}};
    localparam logic signed [BW-1:0] ONE_B = {3'b000, 1'b1, {F{1'b0}}};

    logic en;

    // Input stage: bring handles and progress to the internal scale.
    logic signed [HANDLE_W-1:0] hin, hout;
    logic [PROG_W-1:0]          prog;
    logic signed [AW-1:0]       a_next, hout_conv;
    logic signed [BW-1:0]       b_next;
    logic [XW-1:0]              x_next;
    logic                       e_valid_reg;
    logic [CXW-1:0]             e_ctx_reg;

    assign hin  = $signed(s_tdata[HIN_LSB +: HANDLE_W]);
    assign hout = $signed(s_tdata[HOUT_LSB +: HANDLE_W]);
    assign prog = s_tdata[PROG_LSB +: PROG_W];

    generate
        if (F >= IN_FRAC) begin : g_up
            assign a_next    = AW'(hin) <<< (F - IN_FRAC);
            assign hout_conv = AW'(hout) <<< (F - IN_FRAC);
            assign x_next    = XW'(prog) << (F - IN_FRAC);
        end else begin : g_down
            assign a_next    = AW'(hin >>> (IN_FRAC - F));
            assign hout_conv = AW'(hout >>> (IN_FRAC - F));
            assign x_next    = XW'(prog >> (IN_FRAC - F));
        end
    endgenerate

    assign b_next = ONE_B - BW'(hout_conv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_ctx_reg <= {s_tdata[START_LSB +: VALUE_W], s_tdata[END_LSB +: VALUE_W],
                          a_next, b_next, x_next};
        end
    end

    assign s_tready = en;

    // Bisection chain.
    logic           st_valid [BISECT_STEPS];
    logic [CXW-1:0] st_ctx   [BISECT_STEPS];
    logic [TW-1:0]  st_lo    [BISECT_STEPS];
    logic [TW-1:0]  st_hi    [BISECT_STEPS];
    logic           fin_valid;
    logic [CXW-1:0] fin_ctx;
    logic [TW-1:0]  fin_t;

    assign st_valid[0] = e_valid_reg;
    assign st_ctx[0]   = e_ctx_reg;
    assign st_lo[0]    = '0;
    assign st_hi[0]    = ONE;

    generate
        for (genvar k = 0; k < BISECT_STEPS; k++) begin : g_step
            if (k < BISECT_STEPS - 1) begin : g_mid
                bei_step #(
                    .FRAC_BITS (FRAC_BITS)
                ) u_step (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (en),
                    .in_valid  (st_valid[k]),
                    .in_ctx    (st_ctx[k]),
                    .in_lo     (st_lo[k]),
                    .in_hi     (st_hi[k]),
                    .out_valid (st_valid[k+1]),
                    .out_ctx   (st_ctx[k+1]),
                    .out_lo    (st_lo[k+1]),
                    .out_hi    (st_hi[k+1]),
                    .out_t     ()
                );
            end else begin : g_last
                bei_step #(
                    .FRAC_BITS (FRAC_BITS)
                ) u_step (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (en),
                    .in_valid  (st_valid[k]),
                    .in_ctx    (st_ctx[k]),
                    .in_lo     (st_lo[k]),
                    .in_hi     (st_hi[k]),
                    .out_valid (fin_valid),
                    .out_ctx   (fin_ctx),
                    .out_lo    (),
                    .out_hi    (),
                    .out_t     (fin_t)
                );
            end
        end
    endgenerate

    // Blend and output buffer.
    logic   bl_valid;
    value_t bl_value;

    bei_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fin_valid),
        .in_start  ($signed(fin_ctx[START_POS +: VALUE_W])),
        .in_end    ($signed(fin_ctx[END_POS +: VALUE_W])),
        .in_t      (fin_t),
        .out_valid (bl_valid),
        .out_value (bl_value)
    );

    bei_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (bl_valid),
        .in_data  (bl_value),
        .en       (en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sim/bei_checker.sv @@
`timescale 1ns / 1ps

module bei_checker
    import bei_pkg::*;
#(
    parameter int BISECT_STEPS = BISECT_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   mismatches,
    output int                   pending
);

    typedef logic signed [HANDLE_W-1:0] handle_t;

    // Eased values still owed by the block, oldest request first.
    value_t eased_q[$];
    value_t want;

    // Q.20 input fields brought to the internal scale.
    function automatic longint to_frac(input longint v);
        if (FRAC_BITS >= IN_FRAC) begin
            return v <<< (FRAC_BITS - IN_FRAC);
        end
        return v >>> (IN_FRAC - FRAC_BITS);
    endfunction

    // Fixed-point product, rounded toward minus infinity.
    function automatic longint fmul(input longint p, input longint q);
        return (p * q) >>> FRAC_BITS;
    endfunction

    function automatic longint bezier_x(input longint a, input longint b, input longint t);
        longint unit_v;
        longint u;
        longint tt;
        longint w1;
        longint w2;
        longint w3;
        unit_v = longint'(1) <<< FRAC_BITS;
        u  = unit_v - t;
        tt = fmul(t, t);
        w1 = fmul(fmul(t, u), u);
        w2 = fmul(tt, u);
        w3 = fmul(tt, t);
        return 3 * fmul(a, w1) + 3 * fmul(b, w2) + w3;
    endfunction

    function automatic value_t eased_value(input logic [S_TDATA_W-1:0] d);
        longint  unit_v;
        longint  start_v;
        longint  end_v;
        longint  a;
        longint  b;
        longint  x;
        longint  lo;
        longint  hi;
        longint  t;
        longint  s;
        longint  r;
        handle_t h_in;
        handle_t h_out;
        value_t  v0;
        value_t  v1;
        unit_v  = longint'(1) <<< FRAC_BITS;
        v0      = d[START_LSB +: VALUE_W];
        v1      = d[END_LSB +: VALUE_W];
        h_in    = d[HIN_LSB +: HANDLE_W];
        h_out   = d[HOUT_LSB +: HANDLE_W];
        start_v = longint'(v0);
        end_v   = longint'(v1);
        a       = to_frac(longint'(h_in));
        b       = unit_v - to_frac(longint'(h_out));
        x       = longint'(d[PROG_LSB +: PROG_W]);
        x       = to_frac(x);
        lo      = 0;
        hi      = unit_v;
        t       = 0;
        // The midpoint of the final step is kept, not the narrowed interval.
        for (int i = 0; i < BISECT_STEPS; i++) begin
            t = (lo + hi) >>> 1;
            if (bezier_x(a, b, t) < x) begin
                lo = t;
            end else begin
                hi = t;
            end
        end
        s = fmul(fmul(t, t), 3 * unit_v - 2 * t);
        r = start_v + ((s * (end_v - start_v)) >>> FRAC_BITS);
        if (r > (longint'(1) <<< 31) - 1) begin
            r = (longint'(1) <<< 31) - 1;
        end
        if (r < -(longint'(1) <<< 31)) begin
            r = -(longint'(1) <<< 31);
        end
        return r[VALUE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] eased_value check: %s", $time, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            eased_q.delete();
            mismatches = 0;
            pending    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                eased_q.insert(eased_q.size(), eased_value(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (eased_q.size() == 0) begin
                    report_mismatch($sformatf("result %h with no request waiting", m_tdata));
                end else begin
                    want = eased_q.pop_front();
                    if (m_tdata !== want) begin
                        report_mismatch($sformatf("got %h, expected %h", m_tdata, want));
                    end
                end
            end
            pending = eased_q.size();
        end
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import bei_pkg::*;
();

    localparam int STEPS   = BISECT_STEPS_DEF;
    localparam int FRAC    = FRAC_BITS_DEF;
    localparam int LATENCY = 5 * STEPS + 6;
    localparam int ONE     = 1 << IN_FRAC;

    typedef logic signed [HANDLE_W-1:0] handle_t;
    typedef logic [PROG_W-1:0]          prog_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;

    always #4 aclk = ~aclk;

    bezier_easing_interpolator_top #(
        .BISECT_STEPS(STEPS),
        .FRAC_BITS   (FRAC)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    bei_checker #(
        .BISECT_STEPS(STEPS),
        .FRAC_BITS   (FRAC)
    ) checker_i (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [S_TDATA_W-1:0] easing_word(input value_t start_v,
                                                         input value_t end_v,
                                                         input handle_t h_in,
                                                         input handle_t h_out,
                                                         input prog_t prog);
        logic [S_TDATA_W-1:0] w;
        w = '0;
        w[START_LSB +: VALUE_W] = start_v;
        w[END_LSB +: VALUE_W]   = end_v;
        w[HIN_LSB +: HANDLE_W]  = h_in;
        w[HOUT_LSB +: HANDLE_W] = h_out;
        w[PROG_LSB +: PROG_W]   = prog;
        return w;
    endfunction

    task automatic send_request(input logic [S_TDATA_W-1:0] w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic random_requests(input int count);
        value_t  start_v;
        value_t  end_v;
        handle_t h_in;
        handle_t h_out;
        prog_t   prog;
        for (int i = 0; i < count; i++) begin
            start_v = $urandom;
            end_v   = $urandom;
            // Mostly values of moderate size, at varying scales.
            if ($urandom_range(3) != 0) begin
                start_v = start_v >>> $urandom_range(16, 4);
                end_v   = end_v >>> $urandom_range(16, 4);
            end
            if ($urandom_range(3) != 0) begin
                h_in  = handle_t'(int'($urandom_range(2 * ONE, 0)) - ONE);
                h_out = handle_t'(int'($urandom_range(2 * ONE, 0)) - ONE);
            end else begin
                h_in  = handle_t'($urandom);
                h_out = handle_t'($urandom);
            end
            case ($urandom_range(15))
                0:       prog = '0;
                1:       prog = prog_t'(ONE);
                2, 3:    prog = prog_t'($urandom);
                default: prog = prog_t'($urandom_range(ONE, 0));
            endcase
            send_request(easing_word(start_v, end_v, h_in, h_out, prog));
        end
    endtask

    task automatic directed_requests();
        value_t  vmin;
        value_t  vmax;
        handle_t hmin;
        handle_t hmax;
        vmin = {1'b1, {(VALUE_W-1){1'b0}}};
        vmax = {1'b0, {(VALUE_W-1){1'b1}}};
        hmin = {1'b1, {(HANDLE_W-1){1'b0}}};
        hmax = {1'b0, {(HANDLE_W-1){1'b1}}};
        send_request(easing_word(0, 32'sh10000, handle_t'(0), handle_t'(0), '0));
        send_request(easing_word(0, 32'sh10000, handle_t'(0), handle_t'(0), prog_t'(ONE)));
        send_request(easing_word(0, 32'sh10000, handle_t'(349525), handle_t'(349525),
                                 prog_t'(ONE / 2)));
        // Progress beyond one drives the search toward the end of the curve.
        send_request(easing_word(32'sh20000, -32'sh30000, handle_t'(262144),
                                 handle_t'(786432), '1));
        send_request(easing_word(32'sh20000, -32'sh30000, handle_t'(262144),
                                 handle_t'(786432), prog_t'(ONE + 1)));
        // Handles far outside the nominal range are taken as they are.
        send_request(easing_word(-32'sh8000, 32'sh7FFF, hmin, hmax, prog_t'(ONE / 2)));
        send_request(easing_word(-32'sh8000, 32'sh7FFF, hmax, hmin, prog_t'(ONE / 3)));
        send_request(easing_word(0, 32'sh640000, handle_t'(2 * ONE), handle_t'(2 * ONE),
                                 prog_t'(ONE / 4)));
        send_request(easing_word(0, 32'sh640000, handle_t'(-2 * ONE), handle_t'(-2 * ONE),
                                 prog_t'(3 * ONE / 4)));
        send_request(easing_word(0, 32'sh640000, handle_t'(-1), handle_t'(-1),
                                 prog_t'(ONE - 1)));
        // Full-scale spans, where the blend is closest to overflowing.
        send_request(easing_word(vmin, vmax, handle_t'(0), handle_t'(ONE), prog_t'(ONE)));
        send_request(easing_word(vmax, vmin, handle_t'(ONE), handle_t'(0), prog_t'(ONE)));
        send_request(easing_word(vmin, vmax, handle_t'(2 * ONE), handle_t'(-2 * ONE),
                                 prog_t'(ONE / 2)));
        send_request(easing_word(vmax, vmin, handle_t'(-2 * ONE), handle_t'(2 * ONE),
                                 prog_t'(ONE / 4)));
        send_request(easing_word(vmax, vmax, handle_t'(0), handle_t'(0), '1));
        send_request(easing_word(-1, -1, handle_t'(1), handle_t'(1), prog_t'(1)));
        send_request(easing_word(vmin, vmin, handle_t'(0), handle_t'(0), prog_t'(ONE / 2)));
        // A common ease curve at a few points.
        send_request(easing_word(32'sh10000, 32'sh50000, handle_t'(262144),
                                 handle_t'(786432), prog_t'(314573)));
        send_request(easing_word(32'sh10000, 32'sh50000, handle_t'(262144),
                                 handle_t'(786432), prog_t'(734003)));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_requests();

        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        random_requests(120);

        send_idle_pct  <= 50;
        recv_stall_pct <= 0;
        random_requests(120);

        send_idle_pct  <= 0;
        recv_stall_pct <= 50;
        random_requests(120);

        send_idle_pct  <= 14;
        recv_stall_pct <= 14;
        random_requests(120);

        // Hold the result side off long enough for the pipeline to fill and
        // stall the request side.
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        fork
            random_requests(150);
            begin
                hold_off <= 1'b1;
                repeat (3 * LATENCY) @(posedge aclk);
                hold_off <= 1'b0;
            end
        join

        s_tvalid       <= 1'b0;
        recv_stall_pct <= 0;
        wait (pending == 0);
        repeat (LATENCY + 20) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("** bezier_easing_interpolator_top: PASSED **");
        end else begin
            $display("** bezier_easing_interpolator_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** bezier_easing_interpolator_top: FAILED **");
        $finish;
    end

endmodule
